// File: hdl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants of the go-back-n sender: item, result and job
// records, command, result and timer codes, sequence-space sizes.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // Sequence space and payload width fix the field widths
  localparam int SEQ_SPACE    = 8;
  localparam int SEQ_W        = $clog2(SEQ_SPACE);
  localparam int PAYLOAD_BITS = 64;
  localparam int WINDOW_W     = 3;
  localparam logic [WINDOW_W-1:0] WINDOW_LEN_RESET = 3'd4;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Command codes
  localparam logic [1:0] CMD_SEND    = 2'd0;
  localparam logic [1:0] CMD_ACK     = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_REFUSED = 3'd0;
  localparam logic [2:0] KIND_PACKET  = 3'd1;
  localparam logic [2:0] KIND_ACK_ADV = 3'd2;
  localparam logic [2:0] KIND_ACK_DUP = 3'd3;
  localparam logic [2:0] KIND_ACK_BAD = 3'd4;
  localparam logic [2:0] KIND_NO_DATA = 3'd5;

  // Timer actions
  localparam logic [1:0] TIMER_KEEP  = 2'd0;
  localparam logic [1:0] TIMER_START = 2'd1;
  localparam logic [1:0] TIMER_STOP  = 2'd2;

  typedef struct packed {
    logic [1:0]              command;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [SEQ_W-1:0]        ack_num;
    logic                    ack_ok;
  } item_t;

  typedef struct packed {
    logic [2:0]              kind;
    logic [SEQ_W-1:0]        pkt_seq;
    logic [PAYLOAD_BITS-1:0] pkt_payload;
    logic [1:0]              timer_action;
    logic [SEQ_W-1:0]        timer_seq;
    logic [SEQ_W-1:0]        in_flight;
    logic                    window_full;
    logic                    last;
  } result_t;

  // A job is either one finished result or a resend burst; for a burst,
  // timer_seq carries the window base, in_flight the packet count
  typedef struct packed {
    logic    resend;
    result_t res;
  } job_t;

  typedef enum logic {
    BK_IDLE,
    BK_RESEND
  } back_state_t;

endpackage

// File: hdl/gbn_ram.sv
// ----------------------------------------------------------------------------
// gbn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry into the output register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/gbn_front.sv
// ----------------------------------------------------------------------------
// gbn_front
// Accepts commands, keeps the window (base, next, window length), classifies
// each command and queues a finished result or a resend burst for the back.
// ----------------------------------------------------------------------------
module gbn_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  gbn_pkg::item_t                    item,
  input  logic                              cfg_valid,
  input  logic [gbn_pkg::WINDOW_W-1:0]      cfg_data,
  output logic                              push,
  output gbn_pkg::job_t                     push_job,
  input  logic                              q_full,
  input  logic                              resend_done,
  output logic                              ram_we,
  output logic [gbn_pkg::SEQ_W-1:0]         ram_waddr,
  output logic [gbn_pkg::PAYLOAD_BITS-1:0]  ram_wdata
);

  logic [gbn_pkg::SEQ_W-1:0]    base_seq;
  logic [gbn_pkg::SEQ_W-1:0]    base_seq_next;
  logic [gbn_pkg::SEQ_W-1:0]    next_seq;
  logic [gbn_pkg::SEQ_W-1:0]    next_seq_next;
  logic [gbn_pkg::WINDOW_W-1:0] window_len;
  logic                         resend_pending;

  logic                         accept;
  logic [gbn_pkg::SEQ_W-1:0]    n;
  logic                         full;
  logic [gbn_pkg::SEQ_W-1:0]    n_inc;
  logic [gbn_pkg::SEQ_W-1:0]    ack_off;
  logic [gbn_pkg::SEQ_W-1:0]    ack_base;
  logic [gbn_pkg::SEQ_W-1:0]    ack_n;

  // Hold input while a resend burst is outstanding or the queue is full
  assign busy   = resend_pending || q_full;
  assign accept = start && !busy;

  // Window arithmetic wraps at the power-of-two sequence space
  assign n        = next_seq - base_seq;
  assign full     = ({1'b0, n} >= {1'b0, window_len});
  assign n_inc    = n + gbn_pkg::SEQ_W'(1);
  assign ack_off  = item.ack_num - base_seq;
  assign ack_base = item.ack_num + gbn_pkg::SEQ_W'(1);
  assign ack_n    = next_seq - ack_base;

  assign ram_waddr = next_seq;
  assign ram_wdata = item.payload;

  // Classify the command and build its job
  always_comb begin
    base_seq_next = base_seq;
    next_seq_next = next_seq;
    ram_we        = 1'b0;
    push          = accept && (item.command != gbn_pkg::CMD_NONE);

    push_job.resend           = 1'b0;
    push_job.res.kind         = gbn_pkg::KIND_REFUSED;
    push_job.res.pkt_seq      = '0;
    push_job.res.pkt_payload  = '0;
    push_job.res.timer_action = gbn_pkg::TIMER_KEEP;
    push_job.res.timer_seq    = base_seq;
    push_job.res.in_flight    = n;
    push_job.res.window_full  = full;
    push_job.res.last         = 1'b1;

    case (item.command)
      gbn_pkg::CMD_SEND: begin
        if (!full) begin
          push_job.res.kind         = gbn_pkg::KIND_PACKET;
          push_job.res.pkt_seq      = next_seq;
          push_job.res.pkt_payload  = item.payload;
          push_job.res.timer_action = (n == '0) ? gbn_pkg::TIMER_START
                                                : gbn_pkg::TIMER_KEEP;
          push_job.res.in_flight    = n_inc;
          push_job.res.window_full  = ({1'b0, n_inc} >= {1'b0, window_len});
          ram_we                    = accept;
          next_seq_next             = accept ? n_inc + base_seq : next_seq;
        end
      end
      gbn_pkg::CMD_ACK: begin
        if (!item.ack_ok) begin
          push_job.res.kind = gbn_pkg::KIND_ACK_BAD;
        end else if ((item.ack_num == base_seq - gbn_pkg::SEQ_W'(1)) ||
                     (ack_off >= n)) begin
          // Duplicate or outside the window: report and drop
          push_job.res.kind = gbn_pkg::KIND_ACK_DUP;
        end else begin
          push_job.res.kind        = gbn_pkg::KIND_ACK_ADV;
          push_job.res.in_flight   = ack_n;
          push_job.res.window_full = ({1'b0, ack_n} >= {1'b0, window_len});
          if (ack_n != '0) begin
            push_job.res.timer_action = gbn_pkg::TIMER_START;
            push_job.res.timer_seq    = ack_base;
          end else begin
            push_job.res.timer_action = gbn_pkg::TIMER_STOP;
            push_job.res.timer_seq    = item.ack_num;
          end
          base_seq_next = accept ? ack_base : base_seq;
        end
      end
      gbn_pkg::CMD_TIMEOUT: begin
        if (n == '0) begin
          push_job.res.kind = gbn_pkg::KIND_NO_DATA;
        end else begin
          push_job.resend = 1'b1;
        end
      end
      default: begin
        push_job.res.kind = gbn_pkg::KIND_REFUSED;
      end
    endcase
  end

  // Advance window state and track the outstanding resend burst
  always_ff @(posedge clk) begin
    if (rst) begin
      base_seq       <= '0;
      next_seq       <= '0;
      window_len     <= gbn_pkg::WINDOW_LEN_RESET;
      resend_pending <= 1'b0;
    end else begin
      base_seq <= base_seq_next;
      next_seq <= next_seq_next;
      if (cfg_valid) begin
        window_len <= cfg_data;
      end
      if (push && push_job.resend) begin
        resend_pending <= 1'b1;
      end else if (resend_done) begin
        resend_pending <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/gbn_queue.sv
// ----------------------------------------------------------------------------
// gbn_queue
// Short job FIFO between the front and the back of the sender.
// ----------------------------------------------------------------------------
module gbn_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gbn_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output gbn_pkg::job_t pop_job,
  output logic          empty
);

  localparam int PTR_W = (gbn_pkg::QUEUE_DEPTH > 1) ? $clog2(gbn_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(gbn_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(gbn_pkg::QUEUE_DEPTH - 1);

  gbn_pkg::job_t    slots [gbn_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(gbn_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = slots[rd_ptr];

  // Store a beat at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: hdl/gbn_back.sv
// ----------------------------------------------------------------------------
// gbn_back
// Takes jobs from the queue and drives the result port: a finished result in
// one beat, a resend burst one stored packet per beat, oldest first.
// ----------------------------------------------------------------------------
module gbn_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              empty,
  output logic                              pop,
  input  gbn_pkg::job_t                     pop_job,
  output logic [gbn_pkg::SEQ_W-1:0]         ram_raddr,
  input  logic [gbn_pkg::PAYLOAD_BITS-1:0]  ram_rdata,
  output logic                              resend_done,
  output logic                              result_valid,
  output gbn_pkg::result_t                  result
);

  gbn_pkg::back_state_t      state;
  gbn_pkg::back_state_t      state_next;
  logic [gbn_pkg::SEQ_W-1:0] idx;
  logic [gbn_pkg::SEQ_W-1:0] idx_next;
  logic [gbn_pkg::SEQ_W-1:0] rs_base;
  logic [gbn_pkg::SEQ_W-1:0] rs_n;
  logic                      rs_full;
  logic                      load_burst;
  logic                      result_valid_next;
  gbn_pkg::result_t          result_next;
  logic [gbn_pkg::SEQ_W-1:0] idx_inc;

  assign idx_inc = idx + gbn_pkg::SEQ_W'(1);

  // Next state, RAM address and the next result beat
  always_comb begin
    state_next        = state;
    idx_next          = idx;
    pop               = 1'b0;
    load_burst        = 1'b0;
    resend_done       = 1'b0;
    ram_raddr         = pop_job.res.timer_seq;
    result_valid_next = 1'b0;
    result_next       = pop_job.res;

    case (state)
      gbn_pkg::BK_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (pop_job.resend) begin
            // Start the burst: fetch the oldest packet first
            load_burst = 1'b1;
            idx_next   = '0;
            state_next = gbn_pkg::BK_RESEND;
          end else begin
            result_valid_next = 1'b1;
          end
        end
      end
      gbn_pkg::BK_RESEND: begin
        // Emit the fetched packet and fetch the following one
        ram_raddr                = rs_base + idx_inc;
        result_valid_next        = 1'b1;
        result_next.kind         = gbn_pkg::KIND_PACKET;
        result_next.pkt_seq      = rs_base + idx;
        result_next.pkt_payload  = ram_rdata;
        result_next.timer_action = (idx == '0) ? gbn_pkg::TIMER_START
                                               : gbn_pkg::TIMER_KEEP;
        result_next.timer_seq    = rs_base;
        result_next.in_flight    = rs_n;
        result_next.window_full  = rs_full;
        result_next.last         = (idx_inc == rs_n);
        if (idx_inc == rs_n) begin
          resend_done = 1'b1;
          state_next  = gbn_pkg::BK_IDLE;
        end else begin
          idx_next = idx_inc;
        end
      end
      default: begin
        state_next = gbn_pkg::BK_IDLE;
      end
    endcase
  end

  // State register and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= gbn_pkg::BK_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  // Burst bookkeeping and result payload
  always_ff @(posedge clk) begin
    idx    <= idx_next;
    result <= result_next;
    if (load_burst) begin
      rs_base <= pop_job.res.timer_seq;
      rs_n    <= pop_job.res.in_flight;
      rs_full <= pop_job.res.window_full;
    end
  end

endmodule

// File: hdl/go_back_n_sender_core.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_core
// Go-back-N sender: window of unacknowledged packets, cumulative ACKs and
// timeout-driven resend of the whole window.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Sends and ACKs can
// follow back to back; each gives one result beat, marked by result_valid,
// after its job has passed the job queue and the result register. A timeout
// with n packets in flight gives n result beats on consecutive cycles (last
// set on the final one), the first of them later than a send's beat as the
// payload RAM read is registered, and holds busy high until the burst is
// done, since the stored payloads are read one per cycle from the single read
// port of the payload RAM. Results cannot be held off: the receiver must take
// each beat in the cycle it is shown. The window length register (cfg_data)
// is always ready and should be written only while no command is in progress.
module go_back_n_sender_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  gbn_pkg::item_t                item,
  output logic                          result_valid,
  output gbn_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gbn_pkg::WINDOW_W-1:0]  cfg_data
);

  logic                             q_push;
  gbn_pkg::job_t                    q_push_job;
  logic                             q_full;
  logic                             q_pop;
  gbn_pkg::job_t                    q_pop_job;
  logic                             q_empty;
  logic                             resend_done;
  logic                             ram_we;
  logic [gbn_pkg::SEQ_W-1:0]        ram_waddr;
  logic [gbn_pkg::PAYLOAD_BITS-1:0] ram_wdata;
  logic [gbn_pkg::SEQ_W-1:0]        ram_raddr;
  logic [gbn_pkg::PAYLOAD_BITS-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  gbn_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .push        (q_push),
    .push_job    (q_push_job),
    .q_full      (q_full),
    .resend_done (resend_done),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata)
  );

  gbn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_pop_job),
    .empty    (q_empty)
  );

  gbn_ram #(
    .WIDTH (gbn_pkg::PAYLOAD_BITS),
    .DEPTH (gbn_pkg::SEQ_SPACE)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gbn_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (q_empty),
    .pop          (q_pop),
    .pop_job      (q_pop_job),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .resend_done  (resend_done),
    .result_valid (result_valid),
    .result       (result)
  );

`ifndef NO_ASSERTIONS
  // The front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("job queue overflow");

  // A resend burst is delivered on consecutive cycles
  a_burst_contiguous: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |=> result_valid)
    else $error("resend burst broken");

  // Only packet beats carry sequence number and payload
  a_pkt_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.kind != gbn_pkg::KIND_PACKET)) |->
    ((result.pkt_seq == '0) && (result.pkt_payload == '0)))
    else $error("non-packet result carries packet fields");
`endif

endmodule
